// ----- rtl/dvrt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dvrt_pkg;

  localparam int unsigned ROUTES_DEF    = 16;
  localparam int unsigned LINKS_DEF     = 8;
  localparam int unsigned ID_BITS_DEF   = 64;
  localparam int unsigned CONN_BITS_DEF = 4;

  localparam int unsigned HOP_W = 8;
  localparam logic [HOP_W-1:0] HOP_NONE = 8'd255;
  localparam logic [HOP_W-1:0] HOP_ZERO = 8'd0;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_DELETE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CHANGE     = 2'd0,
    KIND_ANSWER     = 2'd1,
    KIND_TABLE_FULL = 2'd2,
    KIND_LINKS_FULL = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [63:0]      key;
    logic [HOP_W-1:0] bh;
    logic [3:0]       bc;
    logic             cp;
    logic             gw;
    logic [HOP_W-1:0] alt;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/dvrt_link_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dvrt_link_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned CW    = 4
) (
  input  wire                             clk_i,
  input  wire                             we_i,
  input  wire  [AW-1:0]                   waddr_i,
  input  wire  [CW+dvrt_pkg::HOP_W-1:0]   wdata_i,
  input  wire  [AW-1:0]                   raddr_i,
  output logic [CW+dvrt_pkg::HOP_W-1:0]   rdata_o
);

  logic [CW+dvrt_pkg::HOP_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/distance_vector_route_table_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Update: a search over every route slot, then load, find, scan, alt scan and store passes over
// the route's links. Lookup: search, load, then answer. Delete: search, then clear the route.
// Remove walks every route by rank. A stalled result beat holds the walk until it leaves.
// One beat at a time: input ready only while idle. Results leave through an output register.
// Reset clears the route valid bits, link counts, ranks and route count at once.
module distance_vector_route_table_core #(
  parameter int unsigned ROUTES    = dvrt_pkg::ROUTES_DEF,
  parameter int unsigned LINKS     = dvrt_pkg::LINKS_DEF,
  parameter int unsigned ID_BITS   = dvrt_pkg::ID_BITS_DEF,
  parameter int unsigned CONN_BITS = dvrt_pkg::CONN_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [79:0] s_axis_tdata,  // dest_id[63:0], hop_count[71:64], conn_index[75:72]
  input  wire  [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [87:0] m_axis_tdata,  // route_key, best_hops, best_conn, conn_present,
                                     // got_worse, next_hops
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast
);

  localparam int unsigned RW  = (ROUTES > 1) ? $clog2(ROUTES) : 1;
  localparam int unsigned LW  = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int unsigned NW  = $clog2(LINKS + 1);
  localparam int unsigned CTW = $clog2(ROUTES + 1);
  localparam int unsigned AW  = (ROUTES * LINKS > 1) ? $clog2(ROUTES * LINKS) : 1;
  localparam int unsigned CB  = (CONN_BITS < 4) ? CONN_BITS : 4;
  localparam int unsigned HW  = dvrt_pkg::HOP_W;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_SRCH  = 15'h0002,
    S_NEW   = 15'h0004,
    S_LOAD  = 15'h0008,
    S_OLD   = 15'h0010,
    S_FIND  = 15'h0020,
    S_SHIFT = 15'h0040,
    S_BEST  = 15'h0080,
    S_SCAN  = 15'h0100,
    S_ALT   = 15'h0200,
    S_STORE = 15'h0400,
    S_RES   = 15'h0800,
    S_PUSH  = 15'h1000,
    S_FIN   = 15'h2000,
    S_RANK  = 15'h4000
  } state_e;

  state_e st_q, st_d, ret_q, ret_d;
  dvrt_pkg::mode_e mode_q, mode_d;
  logic [ID_BITS-1:0] key_q, key_d;
  logic [HW-1:0] h_q, h_d, old_q, old_d, bh_q, bh_d, alt_q, alt_d;
  logic [CB-1:0] c_q, c_d;
  logic [RW-1:0] s_q, s_d, f_q, f_d, sc_q, sc_d, rk_q, rk_d;
  logic fnd_q, fnd_d, ffree_q, ffree_d, chg_q, chg_d, orig_q, orig_d, wb_q, wb_d;
  logic [NW-1:0] n_q, n_d, j_q, j_d;
  logic [LW-1:0] b_q, b_d;
  logic [CTW-1:0] r_q, r_d, cnt_q, cnt_d;
  logic pv_q, pv_d, ov_q, ov_d, olast_q, olast_d;
  dvrt_pkg::res_t pend_q, pend_d, nres_q, nres_d, out_q, out_d;

  logic [ROUTES-1:0] used_q, used_d;
  logic [ID_BITS-1:0] id_q [ROUTES];
  logic [ID_BITS-1:0] id_d [ROUTES];
  logic [NW-1:0] tot_q [ROUTES];
  logic [NW-1:0] tot_d [ROUTES];
  logic [LW-1:0] best_q [ROUTES];
  logic [LW-1:0] best_d [ROUTES];
  logic [RW-1:0] rank_q [ROUTES];
  logic [RW-1:0] rank_d [ROUTES];
  logic [CB-1:0] bufc_q [LINKS];
  logic [CB-1:0] bufc_d [LINKS];
  logic [HW-1:0] bufh_q [LINKS];
  logic [HW-1:0] bufh_d [LINKS];

  logic          mem_we;
  logic [AW-1:0] base, mem_addr;
  logic [CB+HW-1:0] mem_wdata, mem_rdata;

  logic [NW-1:0] jp1, jm1;
  logic [LW-1:0] jl, bt;
  logic hit, ofree;
  logic [HW-1:0] nh;

  function automatic dvrt_pkg::res_t mk_res(dvrt_pkg::kind_e k, logic [ID_BITS-1:0] key,
                                            logic [HW-1:0] bh, logic [CB-1:0] bc,
                                            logic cp, logic gw, logic [HW-1:0] alt);
    dvrt_pkg::res_t r;
    r.kind = k;
    r.key  = 64'(key);
    r.bh   = bh;
    r.bc   = 4'(bc);
    r.cp   = cp;
    r.gw   = gw;
    r.alt  = alt;
    return r;
  endfunction

  assign base     = AW'(s_q) * AW'(LINKS);
  assign mem_addr = base + AW'(j_q);
  assign jp1      = j_q + NW'(1);
  assign jm1      = j_q - NW'(1);
  assign jl       = j_q[LW-1:0];
  assign ofree    = !ov_q || m_axis_tready;
  assign hit      = used_q[sc_q] && (id_q[sc_q] == key_q);
  assign bt       = (NW'(best_q[s_q]) < n_q) ? best_q[s_q] : '0;
  assign nh       = (n_q != '0) ? bh_q : dvrt_pkg::HOP_NONE;

  always_comb begin
    st_d = st_q; ret_d = ret_q; mode_d = mode_q; key_d = key_q; h_d = h_q; c_d = c_q;
    old_d = old_q; bh_d = bh_q; alt_d = alt_q; s_d = s_q; f_d = f_q; sc_d = sc_q;
    rk_d = rk_q; fnd_d = fnd_q; ffree_d = ffree_q; chg_d = chg_q; orig_d = orig_q;
    wb_d = wb_q; n_d = n_q; j_d = j_q; b_d = b_q; r_d = r_q; cnt_d = cnt_q;
    pv_d = pv_q; olast_d = olast_q; pend_d = pend_q; nres_d = nres_q; out_d = out_q;
    ov_d = ov_q && !m_axis_tready;
    used_d = used_q; id_d = id_q; tot_d = tot_q; best_d = best_q; rank_d = rank_q;
    bufc_d = bufc_q; bufh_d = bufh_q;
    mem_we = 1'b0;
    mem_wdata = {bufc_q[jl], bufh_q[jl]};

    case (st_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d  = dvrt_pkg::mode_e'(s_axis_tuser);
          key_d   = s_axis_tdata[ID_BITS-1:0];
          h_d     = s_axis_tdata[71:64];
          c_d     = s_axis_tdata[72 +: CB];
          sc_d    = '0;
          r_d     = '0;
          fnd_d   = 1'b0;
          ffree_d = 1'b0;
          chg_d   = 1'b0;
          orig_d  = 1'b0;
          wb_d    = 1'b0;
          st_d    = (dvrt_pkg::mode_e'(s_axis_tuser) == dvrt_pkg::MODE_REMOVE) ? S_RANK
                                                                               : S_SRCH;
        end
      end
      S_SRCH: begin
        if (hit && !fnd_q) begin
          fnd_d = 1'b1;
          s_d   = sc_q;
          n_d   = tot_q[sc_q];
          rk_d  = rank_q[sc_q];
        end
        if (!used_q[sc_q] && !ffree_q) begin
          ffree_d = 1'b1;
          f_d     = sc_q;
        end
        if (sc_q == RW'(ROUTES - 1)) begin
          j_d = '0;
          case (mode_q)
            dvrt_pkg::MODE_UPDATE: begin
              if (fnd_d) begin
                st_d = S_LOAD;
              end else if (h_q == dvrt_pkg::HOP_NONE) begin
                st_d = S_IDLE;
              end else if (!ffree_d) begin
                nres_d = mk_res(dvrt_pkg::KIND_TABLE_FULL, key_q, dvrt_pkg::HOP_NONE, '0,
                                1'b0, 1'b0, dvrt_pkg::HOP_NONE);
                ret_d  = S_FIN;
                st_d   = S_PUSH;
              end else begin
                st_d = S_NEW;
              end
            end
            dvrt_pkg::MODE_LOOKUP: begin
              if (fnd_d) begin
                st_d = S_LOAD;
              end else begin
                nres_d = mk_res(dvrt_pkg::KIND_ANSWER, key_q, dvrt_pkg::HOP_NONE, '0,
                                1'b0, 1'b0, dvrt_pkg::HOP_NONE);
                ret_d  = S_FIN;
                st_d   = S_PUSH;
              end
            end
            dvrt_pkg::MODE_DELETE: begin
              if (fnd_d) begin
                used_d[s_d] = 1'b0;
                tot_d[s_d]  = '0;
                for (int i = 0; i < ROUTES; i++) begin
                  if (used_q[i] && rank_q[i] > rk_d) begin
                    rank_d[i] = rank_q[i] - RW'(1);
                  end
                end
                cnt_d = cnt_q - CTW'(1);
              end
              st_d = S_IDLE;
            end
            default: st_d = S_IDLE;
          endcase
        end else begin
          sc_d = sc_q + RW'(1);
        end
      end
      S_NEW: begin
        for (int i = 0; i < ROUTES; i++) begin
          if (used_q[i]) begin
            rank_d[i] = rank_q[i] + RW'(1);
          end
        end
        used_d[f_q] = 1'b1;
        id_d[f_q]   = key_q;
        tot_d[f_q]  = '0;
        best_d[f_q] = '0;
        rank_d[f_q] = '0;
        cnt_d       = cnt_q + CTW'(1);
        s_d         = f_q;
        n_d         = '0;
        j_d         = '0;
        st_d        = S_LOAD;
      end
      S_LOAD: begin
        if (j_q != '0) begin
          bufc_d[jm1[LW-1:0]] = mem_rdata[CB+HW-1:HW];
          bufh_d[jm1[LW-1:0]] = mem_rdata[HW-1:0];
        end
        if (j_q == n_q) begin
          st_d = S_OLD;
        end else begin
          j_d = jp1;
        end
      end
      S_OLD: begin
        b_d   = bt;
        old_d = (n_q != '0) ? bufh_q[bt] : dvrt_pkg::HOP_NONE;
        j_d   = '0;
        st_d  = (mode_q == dvrt_pkg::MODE_LOOKUP) ? S_RES : S_FIND;
      end
      S_FIND: begin
        if (j_q == n_q) begin
          if (mode_q == dvrt_pkg::MODE_UPDATE) begin
            if (n_q == NW'(LINKS)) begin
              nres_d = mk_res(dvrt_pkg::KIND_LINKS_FULL, key_q, dvrt_pkg::HOP_NONE, '0,
                              1'b0, 1'b0, dvrt_pkg::HOP_NONE);
              ret_d  = S_FIN;
              st_d   = S_PUSH;
            end else begin
              bufc_d[n_q[LW-1:0]] = c_q;
              bufh_d[n_q[LW-1:0]] = h_q;
              n_d  = n_q + NW'(1);
              st_d = S_BEST;
            end
          end else begin
            st_d = S_BEST;
          end
        end else if (bufc_q[jl] == c_q) begin
          if (mode_q == dvrt_pkg::MODE_UPDATE) begin
            chg_d      = (NW'(b_q) == j_q) && (bufh_q[jl] != h_q);
            bufh_d[jl] = h_q;
            st_d       = S_BEST;
          end else begin
            orig_d = (bufh_q[jl] == dvrt_pkg::HOP_ZERO);
            if (NW'(b_q) == j_q) begin
              b_d  = '0;
              wb_d = 1'b1;
            end else if (NW'(b_q) > j_q) begin
              b_d = b_q - LW'(1);
            end
            st_d = S_SHIFT;
          end
        end else begin
          j_d = jp1;
        end
      end
      S_SHIFT: begin
        if (jp1 < n_q) begin
          bufc_d[jl] = bufc_q[jp1[LW-1:0]];
          bufh_d[jl] = bufh_q[jp1[LW-1:0]];
          j_d        = jp1;
        end else begin
          n_d  = n_q - NW'(1);
          st_d = S_BEST;
        end
      end
      S_BEST: begin
        bh_d = orig_q ? dvrt_pkg::HOP_NONE : bufh_q[b_q];
        j_d  = '0;
        st_d = S_SCAN;
      end
      S_SCAN: begin
        if (j_q < n_q) begin
          if (orig_q) begin
            bufh_d[jl] = dvrt_pkg::HOP_NONE;
          end else if (bufh_q[jl] < bh_q) begin
            b_d   = jl;
            bh_d  = bufh_q[jl];
            chg_d = 1'b1;
          end
          j_d = jp1;
        end else begin
          best_d[s_q] = b_q;
          tot_d[s_q]  = n_q;
          j_d         = '0;
          alt_d       = dvrt_pkg::HOP_NONE;
          st_d        = S_ALT;
        end
      end
      S_ALT: begin
        if (j_q < n_q) begin
          if (NW'(b_q) != j_q && bufh_q[jl] < alt_q) begin
            alt_d = bufh_q[jl];
          end
          j_d = jp1;
        end else begin
          j_d  = '0;
          st_d = S_STORE;
        end
      end
      S_STORE: begin
        if (j_q < n_q) begin
          mem_we = 1'b1;
          j_d    = jp1;
        end else begin
          st_d = S_RES;
        end
      end
      S_RES: begin
        case (mode_q)
          dvrt_pkg::MODE_UPDATE: begin
            if (bh_q == old_q && !chg_q) begin
              st_d = S_FIN;
            end else begin
              nres_d = mk_res(dvrt_pkg::KIND_CHANGE, key_q, bh_q, bufc_q[b_q], 1'b1,
                              (bh_q > old_q) || (bh_q == dvrt_pkg::HOP_NONE), alt_q);
              ret_d  = S_FIN;
              st_d   = S_PUSH;
            end
          end
          dvrt_pkg::MODE_REMOVE: begin
            if (nh == old_q && !wb_q) begin
              st_d = S_RANK;
            end else begin
              if (n_q != '0) begin
                nres_d = mk_res(dvrt_pkg::KIND_CHANGE, key_q, nh, bufc_q[b_q], 1'b1,
                                nh > old_q, alt_q);
              end else begin
                nres_d = mk_res(dvrt_pkg::KIND_CHANGE, key_q, dvrt_pkg::HOP_NONE, '0,
                                1'b0, nh > old_q, dvrt_pkg::HOP_NONE);
              end
              ret_d = S_RANK;
              st_d  = S_PUSH;
            end
          end
          dvrt_pkg::MODE_LOOKUP: begin
            if (n_q == '0) begin
              nres_d = mk_res(dvrt_pkg::KIND_ANSWER, key_q, dvrt_pkg::HOP_NONE, '0,
                              1'b0, 1'b0, dvrt_pkg::HOP_NONE);
            end else if (old_q != dvrt_pkg::HOP_NONE) begin
              nres_d = mk_res(dvrt_pkg::KIND_ANSWER, key_q, old_q, bufc_q[b_q],
                              1'b1, 1'b0, dvrt_pkg::HOP_NONE);
            end else begin
              nres_d = mk_res(dvrt_pkg::KIND_ANSWER, key_q, old_q, '0,
                              1'b0, 1'b0, dvrt_pkg::HOP_NONE);
            end
            ret_d = S_FIN;
            st_d  = S_PUSH;
          end
          default: st_d = S_FIN;
        endcase
      end
      S_PUSH: begin
        if (!pv_q) begin
          pend_d = nres_q;
          pv_d   = 1'b1;
          st_d   = ret_q;
        end else if (ofree) begin
          out_d   = pend_q;
          olast_d = 1'b0;
          ov_d    = 1'b1;
          pend_d  = nres_q;
          st_d    = ret_q;
        end
      end
      S_FIN: begin
        if (!pv_q) begin
          st_d = S_IDLE;
        end else if (ofree) begin
          out_d   = pend_q;
          olast_d = 1'b1;
          ov_d    = 1'b1;
          pv_d    = 1'b0;
          st_d    = S_IDLE;
        end
      end
      S_RANK: begin
        if (r_q == cnt_q) begin
          st_d = S_FIN;
        end else if (used_q[sc_q] && CTW'(rank_q[sc_q]) == r_q) begin
          s_d    = sc_q;
          key_d  = id_q[sc_q];
          n_d    = tot_q[sc_q];
          j_d    = '0;
          orig_d = 1'b0;
          wb_d   = 1'b0;
          r_d    = r_q + CTW'(1);
          sc_d   = '0;
          st_d   = S_LOAD;
        end else if (sc_q == RW'(ROUTES - 1)) begin
          r_d  = r_q + CTW'(1);
          sc_d = '0;
        end else begin
          sc_d = sc_q + RW'(1);
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ret_q  <= S_FIN;
      pv_q   <= 1'b0;
      ov_q   <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
      used_q <= '0;
      for (int i = 0; i < ROUTES; i++) begin
        tot_q[i]  <= '0;
        rank_q[i] <= '0;
      end
    end else begin
      st_q   <= st_d;
      ret_q  <= ret_d;
      pv_q   <= pv_d;
      ov_q   <= ov_d;
      cnt_q  <= cnt_d;
      n_q    <= n_d;
      used_q <= used_d;
      tot_q  <= tot_d;
      rank_q <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; key_q <= key_d; h_q <= h_d; c_q <= c_d; old_q <= old_d;
    bh_q <= bh_d; alt_q <= alt_d; s_q <= s_d; f_q <= f_d; sc_q <= sc_d; rk_q <= rk_d;
    fnd_q <= fnd_d; ffree_q <= ffree_d; chg_q <= chg_d; orig_q <= orig_d; wb_q <= wb_d;
    j_q <= j_d; b_q <= b_d; r_q <= r_d; olast_q <= olast_d;
    pend_q <= pend_d; nres_q <= nres_d; out_q <= out_d;
    id_q <= id_d; best_q <= best_d; bufc_q <= bufc_d; bufh_q <= bufh_d;
  end

  dvrt_link_mem #(
    .DEPTH (ROUTES * LINKS),
    .AW    (AW),
    .CW    (CB)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {2'b00, out_q.alt, out_q.gw, out_q.cp, out_q.bc, out_q.bh,
                          out_q.key};

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pv_q) else $error("pending result while idle");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CTW'($countones(used_q))) else $error("route count mismatch");
  a_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> pv_q) else $error("non-last beat without follower");
  a_links: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(LINKS)) else $error("link count overflow");

endmodule
`default_nettype wire
